[hdl/et_pkg.sv]
package et_pkg;

  // Identifier buffer geometry
  localparam int IDENT_BUF   = 32;
  localparam int IDENT_DEPTH = IDENT_BUF - 1;
  localparam int LEN_W       = $clog2(IDENT_BUF);
  localparam int IDX_W       = (IDENT_DEPTH > 1) ? $clog2(IDENT_DEPTH) : 1;

  localparam logic [15:0] TOKEN_LIMIT_RST = 16'd256;

  // Fraction digits past this count add nothing (factor has reached zero)
  localparam logic [3:0] FRAC_CNT_MAX = 4'd10;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef enum logic [3:0] {
    KIND_NUMBER  = 4'd0,
    KIND_IDENT   = 4'd1,
    KIND_PLUS    = 4'd2,
    KIND_MINUS   = 4'd3,
    KIND_MUL     = 4'd4,
    KIND_DIV     = 4'd5,
    KIND_OPEN    = 4'd6,
    KIND_CLOSE   = 4'd7,
    KIND_COMMA   = 4'd8,
    KIND_FACT    = 4'd9,
    KIND_PERCENT = 4'd10,
    KIND_EOF     = 4'd11,
    KIND_ERROR   = 4'd12
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CHAR  = 2'd1,
    ERR_SPLIT = 2'd2,
    ERR_SAT   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FLUSH = 2'd1,
    ST_IDENT = 2'd2,
    ST_START = 2'd3
  } state_t;

  typedef struct packed {
    logic accept;
    logic flush;
    logic id_emit;
    logic start;
  } et_cmd_t;

  typedef struct packed {
    logic handled;
    logic to_flush;
    logic flush_num;
    logic flush_id;
    logic id_final;
    logic start_emits;
    logic out_free;
  } et_sts_t;

  typedef struct packed {
    logic digit;
    logic alpha;
    logic space;
    logic point;
  } ch_class_t;

  function automatic ch_class_t classify(input logic [7:0] c);
    ch_class_t r;
    r.digit = (c >= CH_ZERO) && (c <= CH_NINE);
    r.alpha = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
              (c == CH_UNDER);
    r.space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    r.point = (c == CH_POINT);
    return r;
  endfunction

  function automatic kind_t op_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_PLUS:  k = KIND_PLUS;
      CH_MINUS: k = KIND_MINUS;
      CH_STAR:  k = KIND_MUL;
      CH_SLASH: k = KIND_DIV;
      CH_OPEN:  k = KIND_OPEN;
      CH_CLOSE: k = KIND_CLOSE;
      CH_COMMA: k = KIND_COMMA;
      CH_BANG:  k = KIND_FACT;
      CH_PCT:   k = KIND_PERCENT;
      default:  k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // floor(2^32 / 10^k): the weight of the k-th fraction digit
  function automatic logic [31:0] frac_factor(input logic [3:0] k);
    logic [31:0] f;
    case (k)
      4'd1:    f = 32'd429496729;
      4'd2:    f = 32'd42949672;
      4'd3:    f = 32'd4294967;
      4'd4:    f = 32'd429496;
      4'd5:    f = 32'd42949;
      4'd6:    f = 32'd4294;
      4'd7:    f = 32'd429;
      4'd8:    f = 32'd42;
      4'd9:    f = 32'd4;
      default: f = 32'd0;
    endcase
    return f;
  endfunction

endpackage

[hdl/et_ctrl.sv]
module et_ctrl import et_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  et_sts_t sts,
  output et_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.handled) begin
          state_nxt = sts.to_flush ? ST_FLUSH : ST_START;
        end
      end
      ST_FLUSH: begin
        if (sts.flush_num) begin
          if (sts.out_free) state_nxt = ST_START;
        end else if (sts.flush_id) begin
          state_nxt = ST_IDENT;
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_IDENT: begin
        if (sts.out_free && sts.id_final) state_nxt = ST_START;
      end
      ST_START: begin
        if (!sts.start_emits || sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_FLUSH: begin
        if (sts.flush_num) begin
          cmd.flush = sts.out_free;
        end else if (!sts.flush_id) begin
          cmd.flush = 1'b1;
        end
      end
      ST_IDENT: begin
        cmd.id_emit = sts.out_free;
      end
      ST_START: begin
        cmd.start = !sts.start_emits || sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[hdl/et_datapath.sv]
module et_datapath import et_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_input,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [3:0]  out_kind,
  output logic [47:0] out_number_value,
  output logic [7:0]  out_ident_char,
  output logic        out_token_end,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_char_position,
  output logic        out_last,
  input  et_cmd_t     cmd,
  output et_sts_t     sts
);

  // Scan state
  logic [15:0]      limit_r, limit_nxt;
  mode_t            mode_r, mode_nxt;
  logic             seen_point_r, seen_point_nxt;
  logic [31:0]      int_r, int_nxt;
  logic [31:0]      frac_r, frac_nxt;
  logic [3:0]       fcnt_r, fcnt_nxt;
  logic             sat_r, sat_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      tokens_r, tokens_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic [15:0]      tok_start_r, tok_start_nxt;
  logic [IDX_W-1:0] eidx_r, eidx_nxt;

  // Held input beat
  logic [7:0]       pend_ch_r;
  logic             pend_end_r;
  logic [15:0]      pend_pos_r;

  // Output register
  logic             out_valid_r;
  kind_t            out_kind_r;
  logic [47:0]      out_value_r;
  logic [7:0]       out_char_r;
  logic             out_tend_r;
  err_t             out_err_r;
  logic [15:0]      out_pos_r;
  logic             out_last_r;

  // Identifier store
  logic [7:0]       id_mem [IDENT_DEPTH];
  logic             id_we;
  logic [IDX_W-1:0] id_waddr;
  logic [7:0]       id_wdata;

  ch_class_t        in_cls, pend_cls;
  logic             below_now, below_after;
  logic             tail_core, tail_now, tail_after;
  logic             start_active, do_clear;
  logic [3:0]       in_d;
  logic [35:0]      int_prod;
  logic             int_sat;
  logic [3:0]       fcnt_inc;
  logic [31:0]      frac_add;

  logic             out_load;
  kind_t            kind_sel;
  logic [47:0]      value_sel;
  logic [7:0]       char_sel;
  logic             tend_sel;
  err_t             err_sel;
  logic [15:0]      pos_sel;
  logic             last_sel;

  always_comb begin
    in_cls      = classify(in_ch);
    pend_cls    = classify(pend_ch_r);
    below_now   = {1'b0, tokens_r} < {1'b0, limit_r};
    below_after = ({1'b0, tokens_r} + 17'd1) < {1'b0, limit_r};
    tail_core   = pend_end_r || (!pend_cls.space && !pend_cls.digit && !pend_cls.alpha);
    tail_now    = tail_core && below_now;
    tail_after  = tail_core && below_after;
    start_active = !pend_end_r && !pend_cls.space && below_now;

    in_d     = in_ch[3:0];
    int_prod = {4'd0, int_r} * 36'd10 + 36'(in_d);
    int_sat  = |int_prod[35:32];
    fcnt_inc = (fcnt_r == FRAC_CNT_MAX) ? fcnt_r : fcnt_r + 4'd1;
    frac_add = frac_r + 32'(in_d) * frac_factor(fcnt_inc);
  end

  always_comb begin
    sts             = '0;
    sts.handled     = !in_end_of_input &&
                      (((mode_r == MODE_NUM) && (in_cls.digit || (in_cls.point && !seen_point_r))) ||
                       ((mode_r == MODE_IDENT) && (in_cls.digit || in_cls.alpha) &&
                        (len_r < LEN_W'(IDENT_DEPTH))));
    sts.to_flush    = in_end_of_input || (mode_r != MODE_IDLE);
    sts.flush_num   = (mode_r == MODE_NUM) && below_now;
    sts.flush_id    = (mode_r == MODE_IDENT) && below_now && (len_r != '0);
    sts.id_final    = (LEN_W'(eidx_r) + LEN_W'(1)) == len_r;
    sts.start_emits = tail_now;
    sts.out_free    = !out_valid_r || !out_stall;
  end

  always_comb begin
    limit_nxt      = limit_r;
    mode_nxt       = mode_r;
    seen_point_nxt = seen_point_r;
    int_nxt        = int_r;
    frac_nxt       = frac_r;
    fcnt_nxt       = fcnt_r;
    sat_nxt        = sat_r;
    len_nxt        = len_r;
    tokens_nxt     = tokens_r;
    pos_nxt        = pos_r;
    tok_start_nxt  = tok_start_r;
    eidx_nxt       = eidx_r;
    id_we          = 1'b0;
    id_waddr       = len_r[IDX_W-1:0];
    id_wdata       = in_ch;

    if (cfg_wr_en) limit_nxt = cfg_wr_data;

    // Accept: advance position, absorb characters that extend the current token
    if (cmd.accept) begin
      if (!in_end_of_input) pos_nxt = pos_r + 16'd1;
      if (sts.handled) begin
        if (mode_r == MODE_NUM) begin
          if (!in_cls.digit) begin
            seen_point_nxt = 1'b1;
          end else if (!seen_point_r) begin
            int_nxt = int_sat ? '1 : int_prod[31:0];
            if (int_sat) sat_nxt = 1'b1;
          end else begin
            fcnt_nxt = fcnt_inc;
            frac_nxt = frac_add;
          end
        end else begin
          id_we   = 1'b1;
          len_nxt = len_r + LEN_W'(1);
        end
      end
    end

    do_clear = cmd.flush || (cmd.id_emit && sts.id_final) ||
               (cmd.start && (pend_end_r ||
                              (start_active && (pend_cls.digit || pend_cls.alpha))));
    if (do_clear) begin
      mode_nxt       = MODE_IDLE;
      seen_point_nxt = 1'b0;
      int_nxt        = '0;
      frac_nxt       = '0;
      fcnt_nxt       = '0;
      sat_nxt        = 1'b0;
      len_nxt        = '0;
    end

    if (cmd.flush && sts.flush_num) tokens_nxt = tokens_r + 16'd1;

    if (cmd.id_emit) begin
      if (sts.id_final) begin
        eidx_nxt   = '0;
        tokens_nxt = tokens_r + 16'd1;
      end else begin
        eidx_nxt = eidx_r + IDX_W'(1);
      end
    end

    if (cmd.start) begin
      if (pend_end_r) begin
        tokens_nxt    = '0;
        pos_nxt       = '0;
        tok_start_nxt = '0;
      end else if (start_active) begin
        tok_start_nxt = pend_pos_r;
        if (pend_cls.digit) begin
          mode_nxt = MODE_NUM;
          int_nxt  = {28'd0, pend_ch_r[3:0]};
        end else if (pend_cls.alpha) begin
          mode_nxt = MODE_IDENT;
          len_nxt  = LEN_W'(1);
          id_we    = 1'b1;
          id_waddr = '0;
          id_wdata = pend_ch_r;
        end else begin
          tokens_nxt = tokens_r + 16'd1;
        end
      end
    end
  end

  // Result selection for the output register
  always_comb begin
    out_load  = (cmd.flush && sts.flush_num) || cmd.id_emit || (cmd.start && tail_now);
    kind_sel  = KIND_EOF;
    value_sel = '0;
    char_sel  = '0;
    tend_sel  = 1'b1;
    err_sel   = ERR_NONE;
    pos_sel   = pend_pos_r;
    last_sel  = 1'b1;
    if (cmd.flush) begin
      kind_sel  = KIND_NUMBER;
      value_sel = {int_r, frac_r[31:16]};
      err_sel   = sat_r ? ERR_SAT : ERR_NONE;
      pos_sel   = tok_start_r;
      last_sel  = !tail_after;
    end else if (cmd.id_emit) begin
      kind_sel = KIND_IDENT;
      tend_sel = sts.id_final;
      err_sel  = (!pend_end_r && (pend_cls.digit || pend_cls.alpha)) ? ERR_SPLIT : ERR_NONE;
      pos_sel  = tok_start_r;
      last_sel = sts.id_final && !tail_after;
    end else if (pend_end_r) begin
      kind_sel = KIND_EOF;
      pos_sel  = pos_r;
    end else begin
      kind_sel = op_kind(pend_ch_r);
      if (kind_sel == KIND_ERROR) begin
        char_sel = pend_ch_r;
        err_sel  = ERR_CHAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= TOKEN_LIMIT_RST;
      mode_r       <= MODE_IDLE;
      seen_point_r <= 1'b0;
      int_r        <= '0;
      frac_r       <= '0;
      fcnt_r       <= '0;
      sat_r        <= 1'b0;
      len_r        <= '0;
      tokens_r     <= '0;
      pos_r        <= '0;
      tok_start_r  <= '0;
      eidx_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      limit_r      <= limit_nxt;
      mode_r       <= mode_nxt;
      seen_point_r <= seen_point_nxt;
      int_r        <= int_nxt;
      frac_r       <= frac_nxt;
      fcnt_r       <= fcnt_nxt;
      sat_r        <= sat_nxt;
      len_r        <= len_nxt;
      tokens_r     <= tokens_nxt;
      pos_r        <= pos_nxt;
      tok_start_r  <= tok_start_nxt;
      eidx_r       <= eidx_nxt;
      out_valid_r  <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_ch_r  <= in_ch;
      pend_end_r <= in_end_of_input;
      pend_pos_r <= pos_r;
    end
    if (out_load) begin
      out_kind_r  <= kind_sel;
      out_value_r <= value_sel;
      out_char_r  <= cmd.id_emit ? id_mem[eidx_r] : char_sel;
      out_tend_r  <= tend_sel;
      out_err_r   <= err_sel;
      out_pos_r   <= pos_sel;
      out_last_r  <= last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_waddr] <= id_wdata;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_number_value  = out_value_r;
  assign out_ident_char    = out_char_r;
  assign out_token_end     = out_tend_r;
  assign out_error_code    = out_err_r;
  assign out_char_position = out_pos_r;
  assign out_last          = out_last_r;

endmodule

[hdl/expression_tokenizer.sv]
// A character that extends a number or identifier is absorbed at accept, with no result.
// A token boundary steps through flush, one identifier step per buffered character, start;
// one result per cycle while out_stall does not hold the output register. Each result
// shows there the cycle after its step. Throughput: 1 character per cycle inside tokens.
// Reset: synchronous, active low; clears scan state, counters, output valid; token_limit = 256.
module expression_tokenizer import et_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [47:0] out_number_value,
  output logic [7:0]  out_ident_char,
  output logic        out_token_end,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_char_position,
  output logic        out_last
);

  // Controller sequences each input beat through: accept -> flush or emit the
  // pending token -> start the next token or emit an operator, error or EOF; beats that extend a
  // token stop at accept. The datapath holds the scan state, identifier store and the output register.
  et_cmd_t cmd;
  et_sts_t sts;

  et_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  et_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_ch             (in_ch),
    .in_end_of_input   (in_end_of_input),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_number_value  (out_number_value),
    .out_ident_char    (out_ident_char),
    .out_token_end     (out_token_end),
    .out_error_code    (out_error_code),
    .out_char_position (out_char_position),
    .out_last          (out_last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

[hdl/et_checker.sv]
module et_checker import et_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_kind,
  input logic [47:0] out_number_value,
  input logic [7:0]  out_ident_char,
  input logic        out_token_end,
  input logic [1:0]  out_error_code,
  input logic [15:0] out_char_position,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_number_value) && $stable(out_ident_char) && $stable(out_char_position))
    else $error("stalled result beat changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_IDENT) |-> out_token_end)
    else $error("non-identifier token spans several beats");

  a_split_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code == ERR_SPLIT) |-> (out_kind == KIND_IDENT))
    else $error("split flag on a non-identifier token");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_token_end)
    else $error("last beat of a step falls inside a token");

endmodule

bind expression_tokenizer et_checker u_et_checker (.*);

[verif/expression_tokenizer_checker.sv]
`timescale 1ns / 100ps
module expression_tokenizer_checker import et_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_input,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_kind,
  input  logic [47:0] out_number_value,
  input  logic [7:0]  out_ident_char,
  input  logic        out_token_end,
  input  logic [1:0]  out_error_code,
  input  logic [15:0] out_char_position,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    kind_t       kind;
    logic [47:0] value;
    logic [7:0]  ch;
    logic        tend;
    err_t        err;
    logic [15:0] pos;
    logic        last;
  } token_beat_t;

  token_beat_t expected_tokens[$];

  // Shadow of the lexer state
  mode_t       lex_mode;
  logic        in_fraction;
  logic [31:0] int_part;
  logic [31:0] frac_part;
  logic [32:0] frac_weight;
  logic        int_saturated;
  logic [7:0]  ident_buf [IDENT_DEPTH];
  int          ident_len;
  logic [15:0] token_cap;
  logic [15:0] token_count;
  logic [15:0] char_count;
  logic [15:0] token_pos;

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void clear_scan();
    lex_mode      = MODE_IDLE;
    in_fraction   = 1'b0;
    int_part      = '0;
    frac_part     = '0;
    frac_weight   = 33'h1_0000_0000;
    int_saturated = 1'b0;
    ident_len     = 0;
  endfunction

  function automatic void push_token(input kind_t k, input logic [47:0] v, input logic [7:0] c,
                                     input logic te, input err_t e, input logic [15:0] p);
    token_beat_t b;
    b.kind  = k;
    b.value = v;
    b.ch    = c;
    b.tend  = te;
    b.err   = e;
    b.pos   = p;
    b.last  = 1'b0;
    expected_tokens.push_back(b);
  endfunction

  function automatic void add_digit(input logic [3:0] d);
    logic [35:0] wide;
    logic [63:0] sum;
    if (!in_fraction) begin
      wide = {4'd0, int_part} * 36'd10 + {32'd0, d};
      if (wide > 36'hFFFF_FFFF) begin
        int_part      = '1;
        int_saturated = 1'b1;
      end else begin
        int_part = wide[31:0];
      end
    end else begin
      frac_weight = frac_weight / 33'd10;
      sum         = {32'd0, frac_part} + {60'd0, d} * {31'd0, frac_weight};
      frac_part   = sum[31:0];
    end
  endfunction

  // Emit the pending number or identifier, if the cap still allows a token
  function automatic void close_token(input err_t split_err);
    if (lex_mode != MODE_IDLE && token_count < token_cap) begin
      if (lex_mode == MODE_NUM) begin
        push_token(KIND_NUMBER, {int_part, frac_part[31:16]}, 8'd0, 1'b1,
                   int_saturated ? ERR_SAT : ERR_NONE, token_pos);
        token_count++;
      end else if (ident_len > 0) begin
        for (int i = 0; i < ident_len; i++)
          push_token(KIND_IDENT, 48'd0, ident_buf[i], (i + 1 == ident_len), split_err,
                     token_pos);
        token_count++;
      end
    end
    clear_scan();
  endfunction

  function automatic void scan_char(input logic [7:0] c, input logic eoi);
    logic [15:0] here;
    logic        is_digit;
    logic        is_alpha;
    logic        is_space;
    logic        taken;
    kind_t       op;
    int          had;
    token_beat_t tail;
    had = expected_tokens.size();
    if (eoi) begin
      close_token(ERR_NONE);
      if (token_count < token_cap)
        push_token(KIND_EOF, 48'd0, 8'd0, 1'b1, ERR_NONE, char_count);
      clear_scan();
      token_count = '0;
      char_count  = '0;
      token_pos   = '0;
    end else begin
      here     = char_count;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      is_alpha = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
                 (c == CH_UNDER);
      is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      taken    = 1'b0;
      char_count = char_count + 16'd1;

      case (lex_mode)
        MODE_NUM: begin
          if (is_digit) begin
            add_digit(4'(c - CH_ZERO));
            taken = 1'b1;
          end else if (c == CH_POINT && !in_fraction) begin
            in_fraction = 1'b1;
            taken       = 1'b1;
          end else begin
            close_token(ERR_NONE);
          end
        end
        MODE_IDENT: begin
          if (is_digit || is_alpha) begin
            if (ident_len < IDENT_DEPTH) begin
              ident_buf[ident_len] = c;
              ident_len++;
              taken = 1'b1;
            end else begin
              close_token(ERR_SPLIT);
            end
          end else begin
            close_token(ERR_NONE);
          end
        end
        default: ;
      endcase

      if (!taken && !is_space && token_count < token_cap) begin
        token_pos = here;
        if (is_digit) begin
          clear_scan();
          lex_mode = MODE_NUM;
          add_digit(4'(c - CH_ZERO));
        end else if (is_alpha) begin
          clear_scan();
          lex_mode     = MODE_IDENT;
          ident_buf[0] = c;
          ident_len    = 1;
        end else begin
          case (c)
            CH_PLUS:  op = KIND_PLUS;
            CH_MINUS: op = KIND_MINUS;
            CH_STAR:  op = KIND_MUL;
            CH_SLASH: op = KIND_DIV;
            CH_OPEN:  op = KIND_OPEN;
            CH_CLOSE: op = KIND_CLOSE;
            CH_COMMA: op = KIND_COMMA;
            CH_BANG:  op = KIND_FACT;
            CH_PCT:   op = KIND_PERCENT;
            default:  op = KIND_ERROR;
          endcase
          if (op == KIND_ERROR)
            push_token(KIND_ERROR, 48'd0, c, 1'b1, ERR_CHAR, here);
          else
            push_token(op, 48'd0, 8'd0, 1'b1, ERR_NONE, here);
          token_count++;
        end
      end
    end
    // Flag the final beat caused by this character
    if (expected_tokens.size() > had) begin
      tail      = expected_tokens.pop_back();
      tail.last = 1'b1;
      expected_tokens.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin : watch
    token_beat_t want;
    if (!rst_n) begin
      clear_scan();
      token_cap   = TOKEN_LIMIT_RST;
      token_count = '0;
      char_count  = '0;
      token_pos   = '0;
      fail_count  = 0;
      expected_tokens.delete();
    end else begin
      if (cfg_wr_en)
        token_cap = cfg_wr_data;
      if (in_valid && !in_stall)
        scan_char(in_ch, in_end_of_input);
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report($sformatf("unexpected beat kind %0d pos %0d", out_kind, out_char_position));
        end else begin
          want = expected_tokens.pop_front();
          if (out_kind !== want.kind || out_number_value !== want.value ||
              out_ident_char !== want.ch || out_token_end !== want.tend ||
              out_error_code !== want.err || out_char_position !== want.pos ||
              out_last !== want.last)
            report($sformatf({"got kind %0d val %h ch %h end %b err %0d pos %0d last %b;",
                              " want kind %0d val %h ch %h end %b err %0d pos %0d last %b"},
                             out_kind, out_number_value, out_ident_char, out_token_end,
                             out_error_code, out_char_position, out_last,
                             want.kind, want.value, want.ch, want.tend, want.err,
                             want.pos, want.last));
        end
      end
    end
    pending = expected_tokens.size();
  end

endmodule

[verif/expression_tokenizer_test.sv]
`timescale 1ns / 100ps
module expression_tokenizer_test import et_pkg::*;;

  localparam int RESET_CYCLES  = 11;
  // Longest token boundary: flush, one identifier step per buffered character, then start
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_wr_en       = 1'b0;
  logic [15:0] cfg_wr_data     = '0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch           = '0;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [3:0]  out_kind;
  logic [47:0] out_number_value;
  logic [7:0]  out_ident_char;
  logic        out_token_end;
  logic [1:0]  out_error_code;
  logic [15:0] out_char_position;
  logic        out_last;

  int   fail_count;
  int   pending;

  // Idle percentages for the two sides, changed per phase
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off
  logic hold_req      = 1'b0;
  // Beats sent on the input channel
  int   stim_items    = 0;

  string operators = "+-*/(),!%";

  // 8 ns period
  always #4 clk = ~clk;

  expression_tokenizer dut (.*);

  expression_tokenizer_checker checker_i (.*);

  // Receiver: stall at random on the falling edge; honor a hold-off request by
  // holding stall high for a fixed stretch so the block backs up into its input.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: count edges with no beat moving on any port; give up at the limit.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        quiet = 0;
      else
        quiet++;
    end
    $display("expression_tokenizer_test failed");
    $finish;
  end

  // Offer one character beat; call and return on a falling edge. Insert random
  // gaps with noise on the payload, then hold the payload until accepted.
  task automatic send_char(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid        = 1'b0;
      in_ch           = 8'($urandom);
      in_end_of_input = 1'($urandom);
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_ch           = c;
    in_end_of_input = eoi;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    stim_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], 1'b0);
  endtask

  // End of input; the character byte is don't-care, so randomize it
  task automatic send_end();
    send_char(8'($urandom), 1'b1);
  endtask

  // Drop valid, drain every expected beat, then let a pending token settle
  task automatic go_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_wr_data = v;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(52);
    if (r < 26)
      return 8'(CH_LA + r);
    else if (r < 52)
      return 8'(CH_UA + r - 26);
    else
      return CH_UNDER;
  endfunction

  // Mostly well-formed expression pieces with random content, plus noise
  task automatic run_random(input int n);
    int goal;
    int r;
    int len;
    goal = stim_items + n;
    while (stim_items < goal) begin
      r = $urandom_range(99);
      if (r < 30) begin
        // Number: long integer parts saturate; long fractions run the weight to zero
        repeat ($urandom_range(1, 12)) send_char(8'(CH_ZERO + $urandom_range(9)), 1'b0);
        if ($urandom_range(1)) begin
          send_char(CH_POINT, 1'b0);
          repeat ($urandom_range(0, 12)) send_char(8'(CH_ZERO + $urandom_range(9)), 1'b0);
          if ($urandom_range(9) == 0)
            send_char(CH_POINT, 1'b0);
        end
      end else if (r < 52) begin
        // Identifier: mostly short, now and then long enough to split
        len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(28, 70);
        send_char(rand_alpha(), 1'b0);
        repeat (len - 1)
          send_char(($urandom_range(3) == 0) ? 8'(CH_ZERO + $urandom_range(9)) : rand_alpha(),
                    1'b0);
      end else if (r < 72) begin
        send_char(operators[$urandom_range(8)], 1'b0);
      end else if (r < 82) begin
        send_char(($urandom_range(1) == 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)), 1'b0);
      end else if (r < 88) begin
        send_char(8'($urandom), 1'b0);
      end else if (r < 93) begin
        send_char(CH_POINT, 1'b0);
      end else begin
        send_end();
      end
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 51;

    // Directed, at the reset token limit: every operator, an identifier with both
    // cases, underscore and a digit, a number ended by a second point, a stray
    // point, bytes 0xFF and 0x00, then end of input.
    send_text("+-*/(),!%_zA9 0.5.7\t");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(CH_POINT, 1'b0);
    send_end();
    // Lower the limit under the count while a number is pending: drop it and EOF
    send_text("+7");
    go_idle();
    write_limit(16'd1);
    send_end();

    // Random, sender lightly idle and receiver busy
    go_idle();
    write_limit(16'd3);
    run_random(30);
    go_idle();
    write_limit(16'hFFFF);
    run_random(30);

    // Random, the other way round
    go_idle();
    send_idle_pct = 51;
    recv_idle_pct = 20;
    write_limit(16'd2);
    run_random(25);
    go_idle();
    write_limit(16'($urandom_range(4, 300)));
    run_random(40);

    // No idling from here on
    go_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(16'hFFFF);

    // Back-pressure: hold the receiver off and keep offering operators
    hold_req = 1'b1;
    repeat (30) send_char(operators[$urandom_range(8)], 1'b0);
    run_random(40);
    send_end();

    go_idle();
    if (fail_count == 0 && pending == 0)
      $display("expression_tokenizer_test passed");
    else
      $display("expression_tokenizer_test failed");
    $finish;
  end

endmodule
